[design/positional_sequence_store_macros.svh]
// Assertion macros for the positional sequence store.
`ifndef POSITIONAL_SEQUENCE_STORE_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pss assertion failed");

// Next-cycle implication, disabled in reset.
`define PSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pss assertion failed");

`endif

[design/pss_pkg.sv]
// Package: constants, codes and structs of the positional sequence store.
`default_nettype none
package pss_pkg;
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } pss_ram_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic [STAT_W-1:0]        status;
    } pss_result_t;

    typedef struct packed {
        logic             ready;
        logic             res_valid;
        logic [CNT_W-1:0] held;
    } pss_ctl_t;
endpackage
`default_nettype wire

[design/pss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/pss_engine.sv]
// Sequencer: range checks and entry-by-entry shifting through the RAM.
`default_nettype none
module pss_engine (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    input  wire logic [pss_pkg::FUNC_W-1:0]        in_func,
    input  wire logic [pss_pkg::POS_W-1:0]         in_position,
    input  wire logic signed [pss_pkg::DATA_W-1:0] in_value,
    input  wire logic                              out_free,
    input  wire logic [pss_pkg::DATA_W-1:0]        ram_rdata,
    output pss_pkg::pss_ram_req_t                  ram_req,
    output pss_pkg::pss_ctl_t                      ctl,
    output pss_pkg::pss_result_t                   result
);
    import pss_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECIDE    = 9'b000000010,
        S_SHIFT_RD  = 9'b000000100,
        S_SHIFT_WR  = 9'b000001000,
        S_WRITE_NEW = 9'b000010000,
        S_FWD_RD    = 9'b000100000,
        S_FWD_WR    = 9'b001000000,
        S_READ_WAIT = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  rd_reg, rd_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;

    logic [CMP_W-1:0]   pos_w, held_w;
    logic [CNT_W-1:0]   slot;
    logic [CNT_W-1:0]   idx_dn, idx_up, idx_up2;
    logic               ins_full, ins_bad, acc_bad;

    assign pos_w    = CMP_W'(pos_reg);
    assign held_w   = CMP_W'(held_reg);
    assign slot     = CNT_W'(pos_reg - POS_W'(1));
    assign idx_dn   = idx_reg - CNT_W'(1);
    assign idx_up   = idx_reg + CNT_W'(1);
    assign idx_up2  = idx_reg + CNT_W'(2);
    assign ins_full = (held_reg == CNT_W'(DEPTH));
    assign ins_bad  = (pos_reg == '0) || (pos_w > held_w + CMP_W'(1));
    assign acc_bad  = (pos_reg == '0) || (pos_w > held_w);

    always_comb begin
        state_next = state_reg;
        held_next  = held_reg;
        idx_next   = idx_reg;
        func_next  = func_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        rd_next    = rd_reg;
        stat_next  = stat_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg[ADDR_W-1:0];
        ram_req.wdata = ram_rdata;
        ram_req.raddr = slot[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    func_next  = in_func;
                    pos_next   = in_position;
                    val_next   = in_value;
                    rd_next    = '0;
                    stat_next  = STAT_OK;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                ram_req.raddr = slot[ADDR_W-1:0];
                if (func_reg == FUNC_INSERT) begin
                    if (ins_full) begin
                        stat_next  = STAT_FULL;
                        state_next = S_DONE;
                    end else if (ins_bad) begin
                        stat_next  = STAT_RANGE;
                        state_next = S_DONE;
                    end else begin
                        idx_next   = held_reg;
                        state_next = (held_reg > slot) ? S_SHIFT_RD : S_WRITE_NEW;
                    end
                end else if (func_reg == FUNC_REMOVE) begin
                    if (acc_bad) begin
                        stat_next  = STAT_RANGE;
                        state_next = S_DONE;
                    end else begin
                        idx_next = slot;
                        if (slot + CNT_W'(1) < held_reg) begin
                            state_next = S_FWD_RD;
                        end else begin
                            held_next  = held_reg - CNT_W'(1);
                            state_next = S_DONE;
                        end
                    end
                end else if (func_reg == FUNC_READ) begin
                    if (acc_bad) begin
                        stat_next  = STAT_RANGE;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_READ_WAIT;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                ram_req.raddr = idx_dn[ADDR_W-1:0];
                state_next    = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
                idx_next      = idx_dn;
                state_next    = (idx_dn > slot) ? S_SHIFT_RD : S_WRITE_NEW;
            end
            S_WRITE_NEW: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot[ADDR_W-1:0];
                ram_req.wdata = val_reg;
                held_next     = held_reg + CNT_W'(1);
                state_next    = S_DONE;
            end
            S_FWD_RD: begin
                ram_req.raddr = idx_up[ADDR_W-1:0];
                state_next    = S_FWD_WR;
            end
            S_FWD_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
                idx_next      = idx_up;
                if (idx_up2 < held_reg) begin
                    state_next = S_FWD_RD;
                end else begin
                    held_next  = held_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_READ_WAIT: begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
        idx_reg  <= idx_next;
        func_reg <= func_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        rd_reg   <= rd_next;
        stat_reg <= stat_next;
    end

    assign ctl.ready     = (state_reg == S_IDLE);
    assign ctl.res_valid = (state_reg == S_DONE) && out_free;
    assign ctl.held      = held_reg;

    assign result.read_value = rd_reg;
    assign result.count      = COUNT_W'(held_reg);
    assign result.is_empty   = (held_reg == '0);
    assign result.status     = stat_reg;
endmodule
`default_nettype wire

[design/positional_sequence_store.sv]
// Top level: positional sequence store with valid/ready channels.
// Each item is range-checked; a read then fetches its entry, an insert at p shifts
// entries p..count up and writes the value, and a remove shifts those after p down.
// One item at a time; each moved entry costs one RAM read and one RAM write.
// The next item is taken while a finished result waits in the output register.
// Reset (synchronous, active low) empties the sequence; entry storage is not cleared.
`default_nettype none
`include "positional_sequence_store_macros.svh"
module positional_sequence_store (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [pss_pkg::FUNC_W-1:0]         s_func,
    input  wire logic [pss_pkg::POS_W-1:0]          s_position,
    input  wire logic signed [pss_pkg::DATA_W-1:0]  s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [pss_pkg::DATA_W-1:0]       m_read_value,
    output logic [pss_pkg::COUNT_W-1:0]             m_count,
    output logic                                    m_is_empty,
    output logic [pss_pkg::STAT_W-1:0]              m_status
);
    import pss_pkg::*;

    pss_ram_req_t      ram_req;
    pss_ctl_t          ctl;
    pss_result_t       result;
    logic [DATA_W-1:0] ram_rdata;
    logic              out_free;

    logic              m_valid_reg, m_valid_next;
    pss_result_t       m_res_reg, m_res_next;

    assign out_free = !m_valid_reg || m_ready;

    pss_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_func     (s_func),
        .in_position (s_position),
        .in_value    (s_value),
        .out_free    (out_free),
        .ram_rdata   (ram_rdata),
        .ram_req     (ram_req),
        .ctl         (ctl),
        .result      (result)
    );

    pss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (ctl.res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign s_ready      = ctl.ready;
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_res_reg.read_value;
    assign m_count      = m_res_reg.count;
    assign m_is_empty   = m_res_reg.is_empty;
    assign m_status     = m_res_reg.status;

    `PSS_ASSERT_NOW(a_held_max, 1'b1, ctl.held <= CNT_W'(DEPTH))
    `PSS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `PSS_ASSERT_NOW(a_empty_flag, m_valid, m_is_empty == (m_count == '0))
    `PSS_ASSERT_NOW(a_full_count, m_valid && (m_status == STAT_FULL),
        m_count == COUNT_W'(DEPTH))
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for positional_sequence_store: scoreboarded insert, remove and read traffic.
module tb_top;
    import pss_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int                POS_MAX  = (1 << POS_W) - 1;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [FUNC_W-1:0]        s_func;
    logic [POS_W-1:0]         s_position;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_read_value;
    logic [COUNT_W-1:0]       m_count;
    logic                     m_is_empty;
    logic [STAT_W-1:0]        m_status;

    logic signed [DATA_W-1:0] seq_q[$];
    pss_result_t              pending_results[$];
    pss_result_t              want;
    bit                       no_idle;
    int                       fails;
    int                       n_items;
    int                       n_results;
    int                       n_full;
    int                       n_range;
    int                       peak_held;

    positional_sequence_store dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty),
        .m_status     (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // Applies one operation to the predicted sequence and returns its result.
    function automatic pss_result_t store_op_result(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                                    logic signed [DATA_W-1:0] v);
        pss_result_t r;
        int          held;
        int          pos;
        held = seq_q.size();
        pos = int'(p);
        r = '0;
        r.status = STAT_OK;
        case (f)
            FUNC_INSERT: begin
                if (held >= DEPTH)
                    r.status = STAT_FULL;
                else if (pos == 0 || pos > held + 1)
                    r.status = STAT_RANGE;
                else
                    seq_q.insert(pos - 1, v);
            end
            FUNC_REMOVE: begin
                if (pos == 0 || pos > held)
                    r.status = STAT_RANGE;
                else
                    seq_q.delete(pos - 1);
            end
            FUNC_READ: begin
                if (pos == 0 || pos > held)
                    r.status = STAT_RANGE;
                else
                    r.read_value = seq_q[pos - 1];
            end
            default: ;
        endcase
        held = seq_q.size();
        r.count = COUNT_W'(held);
        r.is_empty = (held == 0);
        if (held > peak_held)
            peak_held = held;
        if (r.status == STAT_FULL)
            n_full++;
        if (r.status == STAT_RANGE)
            n_range++;
        return r;
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                             input logic signed [DATA_W-1:0] v);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_func <= f;
        s_position <= p;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(store_op_result(f, p, v));
        n_items++;
        gap = no_idle ? 0 : rand_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed_edges();
        send_item(FUNC_READ,   7'd1,   32'sd5);
        send_item(FUNC_REMOVE, 7'd1,   32'sd5);
        send_item(FUNC_INSERT, 7'd0,   32'sd9);
        send_item(FUNC_INSERT, 7'd2,   32'sd9);
        send_item(FUNC_NOP,    7'd1,   32'sd9);
        send_item(FUNC_INSERT, 7'd1,   32'sh7fffffff);
        send_item(FUNC_INSERT, 7'd1,   32'sh80000000);
        send_item(FUNC_INSERT, 7'd3,   32'sd0);
        send_item(FUNC_INSERT, 7'd2,   -32'sd1);
        send_item(FUNC_READ,   7'd1,   32'sd0);
        send_item(FUNC_READ,   7'd2,   32'sd0);
        send_item(FUNC_READ,   7'd3,   32'sd0);
        send_item(FUNC_READ,   7'd4,   32'sd0);
        send_item(FUNC_READ,   7'd0,   32'sd0);
        send_item(FUNC_READ,   7'd5,   32'sd0);
        send_item(FUNC_READ,   7'd127, 32'sd0);
        send_item(FUNC_NOP,    7'd127, -32'sd1);
        send_item(FUNC_REMOVE, 7'd4,   32'sd0);
        send_item(FUNC_READ,   7'd3,   32'sd0);
        send_item(FUNC_REMOVE, 7'd1,   32'sd0);
        send_item(FUNC_REMOVE, 7'd2,   32'sd0);
        send_item(FUNC_REMOVE, 7'd1,   32'sd0);
        send_item(FUNC_REMOVE, 7'd1,   32'sd0);
    endtask

    task automatic test_fill_to_full();
        while (seq_q.size() < DEPTH)
            send_item(FUNC_INSERT, POS_W'($urandom_range(1, seq_q.size() + 1)), rand_value());
        send_item(FUNC_INSERT, 7'd1,   rand_value());
        send_item(FUNC_INSERT, 7'd0,   rand_value());
        send_item(FUNC_INSERT, 7'd65,  rand_value());
        send_item(FUNC_INSERT, 7'd127, rand_value());
        send_item(FUNC_READ,   7'd64,  32'sd0);
        send_item(FUNC_READ,   7'd65,  32'sd0);
        send_item(FUNC_REMOVE, 7'd64,  32'sd0);
        send_item(FUNC_INSERT, 7'd64,  rand_value());
        while (seq_q.size() > 0) begin
            if ($urandom_range(0, 99) < 30)
                send_item(FUNC_READ, POS_W'($urandom_range(1, seq_q.size())), rand_value());
            send_item(FUNC_REMOVE, POS_W'($urandom_range(1, seq_q.size())), rand_value());
        end
        send_item(FUNC_READ, 7'd1, 32'sd0);
    endtask

    // Mostly legal positions; ins_pct sets the growth bias, about 12% is noise.
    task automatic test_random_mix(input int n, input int ins_pct);
        int                held;
        int                r;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        repeat (n) begin
            held = seq_q.size();
            r = $urandom_range(0, 99);
            if (r < 12) begin
                f = FUNC_W'($urandom_range(0, 3));
                case ($urandom_range(0, 2))
                    0: p = '0;
                    1: p = POS_W'(held + ((f == FUNC_INSERT) ? 2 : 1));
                    default: p = POS_W'($urandom_range(0, POS_MAX));
                endcase
            end else if (r < 12 + ins_pct) begin
                f = FUNC_INSERT;
                p = POS_W'($urandom_range(1, held + 1));
            end else begin
                f = r[0] ? FUNC_REMOVE : FUNC_READ;
                p = (held > 0) ? POS_W'($urandom_range(1, held)) : POS_W'(1);
            end
            send_item(f, p, rand_value());
        end
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0 && !no_idle) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = 0;
                if (!no_idle && $urandom_range(0, 99) < 15)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d count=%0d empty=%0b status=%0d",
                         $time, m_read_value, m_count, m_is_empty, m_status);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (m_read_value !== want.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.read_value, m_read_value);
                    fails++;
                end
                if (m_count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count, m_count);
                    fails++;
                end
                if (m_is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0b actual %0b",
                             $time, want.is_empty, m_is_empty);
                    fails++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                    fails++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_INSERT;
        s_position = '0;
        s_value = '0;
        no_idle = 1'b0;
        fails = 0;
        n_items = 0;
        n_results = 0;
        n_full = 0;
        n_range = 0;
        peak_held = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        wait_drained();
        test_fill_to_full();
        wait_drained();
        test_random_mix(320, 60);
        wait_drained();
        no_idle = 1'b1;
        test_random_mix(150, 45);
        wait_drained();
        no_idle = 1'b0;
        test_random_mix(300, 30);
        wait_drained();
        repeat (200) @(posedge aclk);

        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            fails++;
        end
        $display("Sent %0d items, checked %0d results; peak occupancy %0d of %0d",
                 n_items, n_results, peak_held, DEPTH);
        $display("Rejections seen: %0d full-store inserts, %0d bad positions", n_full, n_range);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[positional_sequence_store.f]
+incdir+design
design/pss_pkg.sv
design/pss_ram.sv
design/pss_engine.sv
design/positional_sequence_store.sv
tb/sv/tb_top.sv
